/* src/plss_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plss_pkg
// Shared types, codes and sizes of the periodic lattice site store.
// ----------------------------------------------------------------------------
package plss_pkg;

	// Hardware limits and parameter defaults
	localparam int HW_DIMS            = 4;
	localparam int COORD_W            = 4;
	localparam int EXTENT_W           = 5;
	localparam int DIMS_W             = 3;
	localparam int IDX_W              = 20;   // holds every row-major index for extents up to 31
	localparam int DATA_W             = 32;   // width of value fields on the ports
	localparam int CFG_INDEX_W        = 3;
	localparam int QUEUE_DEPTH        = 4;    // power of two: pointers wrap naturally
	localparam int MAX_DIMS_DEFAULT   = 4;
	localparam int SITES_DEFAULT      = 4096;
	localparam int VALUE_BITS_DEFAULT = 32;

	// Configuration register indexes
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_DIMS = 3'd0,
		REG_EXT0 = 3'd1,
		REG_EXT1 = 3'd2,
		REG_EXT2 = 3'd3,
		REG_EXT3 = 3'd4
	} reg_index_t;

	localparam logic [DIMS_W-1:0]   DIMS_RESET = 3'd3;
	localparam logic [EXTENT_W-1:0] EXT0_RESET = 5'd16;
	localparam logic [EXTENT_W-1:0] EXT1_RESET = 5'd16;
	localparam logic [EXTENT_W-1:0] EXT2_RESET = 5'd16;
	localparam logic [EXTENT_W-1:0] EXT3_RESET = 5'd1;

	typedef enum logic [1:0] {
		ACT_READ  = 2'd0,
		ACT_WRITE = 2'd1,
		ACT_NEIGH = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_COORD = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		JOB_READ  = 2'd0,
		JOB_WRITE = 2'd1,
		JOB_FLAG  = 2'd2
	} job_kind_t;

	typedef struct packed {
		logic [DIMS_W-1:0]                dims;
		logic [HW_DIMS-1:0][EXTENT_W-1:0] ext;
	} cfg_t;

	// One store access handed from the front to the back
	typedef struct packed {
		job_kind_t         kind;
		logic [IDX_W-1:0]  idx;
		logic [DATA_W-1:0] wval;
		logic [1:0]        dim;
		logic              up;
		status_t           status;
		logic              last;
	} job_t;

	typedef struct packed {
		logic [DATA_W-1:0] value;
		logic [1:0]        dim;
		logic              up;
		status_t           status;
		logic              last;
	} res_t;

endpackage

/* src/plss_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plss_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module plss_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Read data holds until the next read.
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata <= mem_q[addr];
			end
		end
	end

endmodule

/* src/plss_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plss_queue
// Short job queue between the front and the back of the site store.
// ----------------------------------------------------------------------------
module plss_queue
	import plss_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	output logic valid,
	input  logic pop,
	output job_t pop_job
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	job_t             entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign full    = (count_q == (PTR_W+1)'(QUEUE_DEPTH));
	assign valid   = (count_q != '0);
	assign pop_job = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

/* src/plss_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plss_front
// Accepts actions, checks coordinates, forms row-major indexes and strides,
// and issues one store job per result into the queue.
// ----------------------------------------------------------------------------
module plss_front
	import plss_pkg::*;
#(
	parameter int MAX_DIMS = MAX_DIMS_DEFAULT,
	parameter int SITES    = SITES_DEFAULT
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cfg_t                      cfg,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  action_t                   in_action,
	input  logic [HW_DIMS*COORD_W-1:0] in_coords,
	input  logic [DATA_W-1:0]         in_wval,
	input  logic                      q_full,
	output logic                      q_push,
	output job_t                      q_job
);

	localparam int DLIM = (MAX_DIMS < HW_DIMS) ? MAX_DIMS : HW_DIMS;
	localparam int MUL_W = IDX_W + EXTENT_W;

	typedef enum logic [1:0] {
		S_IDLE,
		S_INDEX,
		S_EMIT,
		S_NEIGH
	} state_t;

	state_t                         state_q;
	logic [1:0]                     t_q;
	logic [1:0]                     dm1_q;
	action_t                        act_q;
	logic [HW_DIMS-1:0][COORD_W-1:0] crd_q;
	logic [DATA_W-1:0]              wval_q;
	logic [IDX_W-1:0]               base_q;
	logic [IDX_W-1:0]               prod_q;
	logic [IDX_W-1:0]               stride_q [HW_DIMS];
	logic [1:0]                     nd_q;
	logic                           nup_q;
	status_t                        flag_q;

	logic [DIMS_W-1:0]               d_eff;
	logic [1:0]                      dm1;
	logic                            bad;
	logic [HW_DIMS-1:0][COORD_W-1:0] crd_in;
	logic [1:0]                      j;
	logic [MUL_W-1:0]                hmul;
	logic [MUL_W-1:0]                smul;
	logic [EXTENT_W-1:0]             ne;
	logic [COORD_W-1:0]              nc;
	logic [EXTENT_W-1:0]             mop;
	logic [MUL_W-1:0]                nmul;
	logic [IDX_W-1:0]                nidx;
	logic                            nlast;
	job_t                            emit_job;
	job_t                            neigh_job;

	assign crd_in = in_coords;

	always_comb begin
		if (cfg.dims == '0) begin
			d_eff = DIMS_W'(1);
		end else if (cfg.dims > DIMS_W'(DLIM)) begin
			d_eff = DIMS_W'(DLIM);
		end else begin
			d_eff = cfg.dims;
		end
		dm1 = 2'(d_eff - 1'b1);
		bad = 1'b0;
		for (int i = 0; i < HW_DIMS; i++) begin
			if ((2'(i) <= dm1) && ({1'b0, crd_in[i]} >= cfg.ext[i])) begin
				bad = 1'b1;
			end
		end
	end

	// Horner step for the base index, running product for the strides
	always_comb begin
		j    = dm1_q - t_q;
		hmul = MUL_W'(base_q) * MUL_W'(cfg.ext[t_q]) + MUL_W'(crd_q[t_q]);
		smul = MUL_W'(prod_q) * MUL_W'(cfg.ext[j]);
	end

	always_comb begin
		emit_job        = '0;
		emit_job.wval   = wval_q;
		emit_job.idx    = base_q;
		emit_job.last   = 1'b1;
		emit_job.status = flag_q;
		if (flag_q != ST_OK) begin
			emit_job.kind = JOB_FLAG;
		end else if (32'(base_q) >= 32'(SITES)) begin
			emit_job.kind   = JOB_FLAG;
			emit_job.status = ST_RANGE;
		end else if (act_q == ACT_WRITE) begin
			emit_job.kind = JOB_WRITE;
		end else begin
			emit_job.kind = JOB_READ;
		end
	end

	// Neighbour index from the base: a step of one stride, or a wrap across
	// the whole extent when the coordinate sits on an edge.
	always_comb begin
		ne   = cfg.ext[nd_q];
		nc   = crd_q[nd_q];
		mop  = nup_q ? EXTENT_W'(nc) : (ne - 1'b1);
		nmul = MUL_W'(mop) * MUL_W'(stride_q[nd_q]);
		if (!nup_q) begin
			nidx = (nc == '0) ? (base_q + IDX_W'(nmul)) : (base_q - stride_q[nd_q]);
		end else begin
			nidx = (({1'b0, nc} + 1'b1) == ne) ? (base_q - IDX_W'(nmul))
			                                   : (base_q + stride_q[nd_q]);
		end
		nlast            = nup_q && (nd_q == dm1_q);
		neigh_job        = '0;
		neigh_job.idx    = nidx;
		neigh_job.wval   = wval_q;
		neigh_job.dim    = nd_q;
		neigh_job.up     = nup_q;
		neigh_job.last   = nlast;
		if (32'(nidx) >= 32'(SITES)) begin
			neigh_job.kind   = JOB_FLAG;
			neigh_job.status = ST_RANGE;
		end else begin
			neigh_job.kind   = JOB_READ;
			neigh_job.status = ST_OK;
		end
	end

	assign in_ready = (state_q == S_IDLE);
	assign q_push   = !q_full && ((state_q == S_EMIT) || (state_q == S_NEIGH));
	assign q_job    = (state_q == S_NEIGH) ? neigh_job : emit_job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			t_q     <= '0;
			dm1_q   <= '0;
			nd_q    <= '0;
			nup_q   <= 1'b0;
			act_q   <= ACT_READ;
			flag_q  <= ST_OK;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						act_q  <= in_action;
						crd_q  <= crd_in;
						wval_q <= in_wval;
						dm1_q  <= dm1;
						base_q <= '0;
						prod_q <= IDX_W'(1);
						t_q    <= '0;
						nd_q   <= '0;
						nup_q  <= 1'b0;
						if (in_action == ACT_NONE) begin
							state_q <= S_IDLE;
						end else if (bad) begin
							flag_q  <= ST_COORD;
							state_q <= S_EMIT;
						end else begin
							flag_q  <= ST_OK;
							state_q <= S_INDEX;
						end
					end
				end
				S_INDEX: begin
					base_q      <= IDX_W'(hmul);
					prod_q      <= IDX_W'(smul);
					stride_q[j] <= prod_q;
					t_q         <= t_q + 1'b1;
					if (t_q == dm1_q) begin
						state_q <= (act_q == ACT_NEIGH) ? S_NEIGH : S_EMIT;
					end
				end
				S_EMIT: begin
					if (!q_full) begin
						state_q <= S_IDLE;
					end
				end
				S_NEIGH: begin
					if (!q_full) begin
						if (nlast) begin
							state_q <= S_IDLE;
						end else if (nup_q) begin
							nup_q <= 1'b0;
							nd_q  <= nd_q + 1'b1;
						end else begin
							nup_q <= 1'b1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* src/plss_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plss_back
// Executes store jobs against the site RAM and holds the result register.
// ----------------------------------------------------------------------------
module plss_back
	import plss_pkg::*;
#(
	parameter int SITES      = SITES_DEFAULT,
	parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
	input  logic clk,
	input  logic arst_n,
	input  logic q_valid,
	input  job_t q_job,
	output logic q_pop,
	output logic out_valid,
	input  logic out_ready,
	output res_t out_res
);

	localparam int ADDR_W = $clog2(SITES);

	logic                  s1_valid_q;
	logic                  s1_ram_s1;
	res_t                  s1_res_s1;
	logic                  out_valid_q;
	res_t                  out_res_q;

	logic                  adv1;
	logic                  issue;
	logic                  ram_we;
	logic [ADDR_W-1:0]     ram_addr;
	logic [VALUE_BITS-1:0] ram_wdata;
	logic [VALUE_BITS-1:0] ram_rdata;
	res_t                  s1_next;
	res_t                  s1_res;

	// The RAM read register only moves on a new read, and a read is only
	// issued when the previous one leaves stage one.
	assign adv1     = s1_valid_q && (!out_valid_q || out_ready);
	assign issue    = q_valid && (!s1_valid_q || adv1);
	assign q_pop    = issue;
	assign ram_we   = (q_job.kind == JOB_WRITE);
	assign ram_addr = ADDR_W'(q_job.idx);
	assign ram_wdata = VALUE_BITS'(q_job.wval);

	plss_ram #(
		.WIDTH (VALUE_BITS),
		.DEPTH (SITES)
	) u_ram (
		.clk   (clk),
		.en    (issue),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	always_comb begin
		s1_next        = '0;
		s1_next.dim    = q_job.dim;
		s1_next.up     = q_job.up;
		s1_next.status = q_job.status;
		s1_next.last   = q_job.last;
		if (q_job.kind == JOB_WRITE) begin
			s1_next.value = DATA_W'(ram_wdata);
		end
		s1_res = s1_res_s1;
		if (s1_ram_s1) begin
			s1_res.value = DATA_W'(ram_rdata);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (issue) begin
				s1_valid_q <= 1'b1;
			end else if (adv1) begin
				s1_valid_q <= 1'b0;
			end
			if (adv1) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			s1_res_s1 <= s1_next;
			s1_ram_s1 <= (q_job.kind == JOB_READ);
		end
		if (adv1) begin
			out_res_q <= s1_res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;

	// A job held in stage one must never be overwritten by a new issue.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !adv1) |-> !issue)
		else $error("stage one overwritten while stalled");

	// Every issued job occupies stage one in the following cycle.
	a_issue_lands: assert property (@(posedge clk) disable iff (!arst_n)
		issue |=> s1_valid_q)
		else $error("issued job lost before stage one");

	// A waiting result is never replaced before it has been taken.
	a_result_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> $stable(out_res_q))
		else $error("pending result changed");

endmodule

/* src/periodic_lattice_site_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_lattice_site_store
// Site store of a lattice of up to four dimensions with periodic neighbours.
// ----------------------------------------------------------------------------
// Actions arrive on the s_ stream (tuser selects read, write or neighbour
// fetch); results leave on the m_ stream, tlast marking the final result of
// each action and tuser carrying the status. The user writes extents and the dimension count
// through the plain cfg_ write port while the block is idle; the block does not enforce it.
//
// The front holds one action at a time: it forms the row-major index and the
// strides with one Horner step per dimension, then issues one job per cycle,
// while the queue is not full, into a four-entry queue. The back takes one job
// a cycle from the queue into the single-port site RAM while its stages can
// advance, so results leave at one per cycle while the receiver is ready; each
// result passes the queue, the RAM stage and then the result register.
//
// Reset restores the default extents (16, 16, 16, 1) and three dimensions;
// the site RAM is not cleared and a site must be written before it is read.
// When the receiver stalls, the result register holds, the RAM stage and the
// queue fill, and the front then stops taking new actions.
// ----------------------------------------------------------------------------
module periodic_lattice_site_store
	import plss_pkg::*;
#(
	parameter int MAX_DIMS   = MAX_DIMS_DEFAULT,
	parameter int SITES      = SITES_DEFAULT,
	parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [EXTENT_W-1:0]    cfg_data,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [47:0]            s_tdata,   // coord_0, coord_1, coord_2, coord_3, write_value
	input  logic [1:0]             s_tuser,   // action
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [39:0]            m_tdata,   // site_value, neighbour_dim, neighbour_up, zero fill
	output logic [1:0]             m_tuser,   // status
	output logic                   m_tlast
);

	cfg_t cfg_q;
	logic q_full;
	logic q_push;
	job_t push_job;
	logic q_valid;
	logic q_pop;
	job_t pop_job;
	res_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dims   <= DIMS_RESET;
			cfg_q.ext[0] <= EXT0_RESET;
			cfg_q.ext[1] <= EXT1_RESET;
			cfg_q.ext[2] <= EXT2_RESET;
			cfg_q.ext[3] <= EXT3_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DIMS: cfg_q.dims   <= cfg_data[DIMS_W-1:0];
				REG_EXT0: cfg_q.ext[0] <= cfg_data;
				REG_EXT1: cfg_q.ext[1] <= cfg_data;
				REG_EXT2: cfg_q.ext[2] <= cfg_data;
				REG_EXT3: cfg_q.ext[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	plss_front #(
		.MAX_DIMS (MAX_DIMS),
		.SITES    (SITES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_action (action_t'(s_tuser)),
		.in_coords (s_tdata[15:0]),
		.in_wval   (s_tdata[47:16]),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_job     (push_job)
	);

	plss_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (push_job),
		.full     (q_full),
		.valid    (q_valid),
		.pop      (q_pop),
		.pop_job  (pop_job)
	);

	plss_back #(
		.SITES      (SITES),
		.VALUE_BITS (VALUE_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_job     (pop_job),
		.q_pop     (q_pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (res)
	);

	assign m_tdata = {5'b0, res.up, res.dim, res.value};
	assign m_tuser = res.status;
	assign m_tlast = res.last;

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench of the periodic lattice site store.
// ----------------------------------------------------------------------------
// Reads, writes and neighbour fetches are sent on the input stream under a
// series of lattice shapes. The shapes cover one to four dimensions, extents
// of zero, one and sixteen, and dimension counts outside the legal range.
// A scoreboard keeps its own copy of the lattice shape and of the site
// values, predicts every result and compares each output transfer in order.
// A site is always written before any read or neighbour fetch reaches it.
// Each phase lets the input stream, the output stream, both or neither idle at random.
// ----------------------------------------------------------------------------
module tb;
	import plss_pkg::*;

	localparam int SITE_COUNT   = SITES_DEFAULT;
	localparam int DRAIN_CYCLES = 40;
	localparam int CYCLE_LIMIT  = 500000;

	class lattice_scoreboard;
		logic [DIMS_W-1:0]   dims_reg;
		logic [EXTENT_W-1:0] ext_reg [HW_DIMS];
		logic [DATA_W-1:0]   site_mirror [SITE_COUNT];
		res_t                pending_results [$];
		int                  mismatches;

		function new();
			dims_reg   = DIMS_RESET;
			ext_reg[0] = EXT0_RESET;
			ext_reg[1] = EXT1_RESET;
			ext_reg[2] = EXT2_RESET;
			ext_reg[3] = EXT3_RESET;
			mismatches = 0;
		endfunction

		function void write_reg(reg_index_t idx, logic [EXTENT_W-1:0] val);
			case (idx)
				REG_DIMS: dims_reg   = val[DIMS_W-1:0];
				REG_EXT0: ext_reg[0] = val;
				REG_EXT1: ext_reg[1] = val;
				REG_EXT2: ext_reg[2] = val;
				REG_EXT3: ext_reg[3] = val;
				default: ;
			endcase
		endfunction

		// A count of zero acts as one and anything above four as four.
		function int dims_eff();
			if (dims_reg == 0)
				return 1;
			if (dims_reg > HW_DIMS)
				return HW_DIMS;
			return int'(dims_reg);
		endfunction

		function bit coords_bad(logic [15:0] crd);
			for (int i = 0; i < dims_eff(); i++)
				if ({1'b0, crd[4*i +: 4]} >= ext_reg[i])
					return 1'b1;
			return 1'b0;
		endfunction

		function int unsigned row_index(logic [15:0] crd);
			int unsigned idx;
			idx = 0;
			for (int i = 0; i < dims_eff(); i++)
				idx = idx * ext_reg[i] + crd[4*i +: 4];
			return idx;
		endfunction

		function logic [15:0] neighbour_of(logic [15:0] crd, int dim, bit up);
			logic [15:0]         moved;
			logic [EXTENT_W-1:0] c;
			logic [EXTENT_W-1:0] e;
			moved = crd;
			c = {1'b0, crd[4*dim +: 4]};
			e = ext_reg[dim];
			if (!up)
				c = (c == 0) ? e - 1'b1 : c - 1'b1;
			else
				c = (c + 1'b1 == e) ? '0 : c + 1'b1;
			moved[4*dim +: 4] = c[3:0];
			return moved;
		endfunction

		function void add_expected(logic [DATA_W-1:0] v, int dim, bit up, status_t st,
				bit last);
			res_t r;
			r.value  = v;
			r.dim    = dim[1:0];
			r.up     = up;
			r.status = st;
			r.last   = last;
			pending_results = {pending_results, r};
		endfunction

		function void note_action(action_t act, logic [47:0] data);
			logic [15:0]       crd;
			logic [DATA_W-1:0] wv;
			logic [15:0]       nb;
			int unsigned       idx;
			int                nd;
			crd = data[15:0];
			wv  = data[47:16];
			nd  = dims_eff();
			if (act == ACT_NONE)
				return;
			if (coords_bad(crd)) begin
				add_expected('0, 0, 1'b0, ST_COORD, 1'b1);
				return;
			end
			idx = row_index(crd);
			case (act)
				ACT_READ: begin
					if (idx >= SITE_COUNT)
						add_expected('0, 0, 1'b0, ST_RANGE, 1'b1);
					else
						add_expected(site_mirror[idx], 0, 1'b0, ST_OK, 1'b1);
				end
				ACT_WRITE: begin
					if (idx >= SITE_COUNT) begin
						add_expected('0, 0, 1'b0, ST_RANGE, 1'b1);
					end else begin
						site_mirror[idx] = wv;
						add_expected(wv, 0, 1'b0, ST_OK, 1'b1);
					end
				end
				default: begin
					for (int d = 0; d < nd; d++) begin
						for (int u = 0; u < 2; u++) begin
							nb  = neighbour_of(crd, d, u[0]);
							idx = row_index(nb);
							if (idx >= SITE_COUNT)
								add_expected('0, d, u[0], ST_RANGE,
									d == nd - 1 && u == 1);
							else
								add_expected(site_mirror[idx], d, u[0], ST_OK,
									d == nd - 1 && u == 1);
						end
					end
				end
			endcase
		endfunction

		function void check_result(logic [DATA_W-1:0] v, logic [1:0] dim, logic up,
				logic [1:0] st, logic last);
			res_t want;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: value %h dim %0d up %0d status %0d last %0d",
						v, dim, up, st, last);
				return;
			end
			want = pending_results.pop_front();
			if (want.value !== v || want.dim !== dim || want.up !== up ||
					want.status !== st || want.last !== last) begin
				mismatches++;
				if (mismatches <= 10) begin
					$write("mismatch: expected value %h dim %0d up %0d status %0d last %0d,",
						want.value, want.dim, want.up, want.status, want.last);
					$display(" got value %h dim %0d up %0d status %0d last %0d",
						v, dim, up, st, last);
				end
			end
		endfunction
	endclass

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   cfg_we    = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [EXTENT_W-1:0]    cfg_data  = '0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [47:0]            s_tdata   = '0;   // coord_0, coord_1, coord_2, coord_3, write_value
	logic [1:0]             s_tuser   = '0;   // action
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [39:0]            m_tdata;          // site_value, neighbour_dim, neighbour_up, zero fill
	logic [1:0]             m_tuser;          // status
	logic                   m_tlast;

	lattice_scoreboard sb = new();
	bit                site_written [SITE_COUNT];
	int                src_idle   = 0;
	int                dst_stall  = 0;
	int                cycle_count = 0;

	periodic_lattice_site_store dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #5 clk = ~clk;

	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= dst_stall);

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata[31:0], m_tdata[33:32], m_tdata[34], m_tuser, m_tlast);
		if (arst_n && s_tvalid && s_tready)
			sb.note_action(action_t'(s_tuser), s_tdata);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("periodic_lattice_site_store test failed");
			$finish;
		end
	end

	function automatic logic [15:0] pack_coords(int c0, int c1, int c2, int c3);
		return {c3[3:0], c2[3:0], c1[3:0], c0[3:0]};
	endfunction

	// tvalid is only lowered when a gap is taken, so a transfer that follows
	// straight on never sees two assignments to it in one step.
	task automatic send_item(input action_t act, input logic [15:0] crd,
			input logic [DATA_W-1:0] wv);
		if ($urandom_range(99) < src_idle) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < src_idle);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {wv, crd};
		s_tuser  <= act;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic fill_site(input logic [15:0] crd);
		int unsigned idx;
		idx = sb.row_index(crd);
		if (idx < SITE_COUNT && !site_written[idx]) begin
			site_written[idx] = 1'b1;
			send_item(ACT_WRITE, crd, $urandom());
		end
	endtask

	// Any site that the action is going to read gets a write of its own first.
	task automatic issue(input action_t act, input logic [15:0] crd,
			input logic [DATA_W-1:0] wv);
		int unsigned idx;
		if (!sb.coords_bad(crd)) begin
			idx = sb.row_index(crd);
			if (act == ACT_READ) begin
				fill_site(crd);
			end else if (act == ACT_NEIGH) begin
				for (int d = 0; d < sb.dims_eff(); d++) begin
					fill_site(sb.neighbour_of(crd, d, 1'b0));
					fill_site(sb.neighbour_of(crd, d, 1'b1));
				end
			end else if (act == ACT_WRITE && idx < SITE_COUNT) begin
				site_written[idx] = 1'b1;
			end
		end
		send_item(act, crd, wv);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (sb.pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input reg_index_t idx, input logic [EXTENT_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		sb.write_reg(idx, val);
	endtask

	task automatic random_items(input int count);
		action_t     act;
		logic [15:0] crd;
		int          r;
		int          c;
		repeat (count) begin
			r = $urandom_range(99);
			act = (r < 30) ? ACT_READ : (r < 55) ? ACT_WRITE : (r < 95) ? ACT_NEIGH : ACT_NONE;
			for (int i = 0; i < HW_DIMS; i++) begin
				// Mostly coordinates inside the lattice; now and then any value.
				if (i >= sb.dims_eff() || sb.ext_reg[i] == 0 || $urandom_range(19) == 0)
					c = $urandom_range(15);
				else
					c = $urandom_range(int'(sb.ext_reg[i]) - 1);
				crd[4*i +: 4] = c[3:0];
			end
			issue(act, crd, $urandom());
		end
	endtask

	task automatic run_phase(input logic [DIMS_W-1:0] dims, input int e0, input int e1,
			input int e2, input int e3, input int count, input int mode);
		wait_idle();
		cfg_write(REG_DIMS, {2'b00, dims});
		cfg_write(REG_EXT0, e0[EXTENT_W-1:0]);
		cfg_write(REG_EXT1, e1[EXTENT_W-1:0]);
		cfg_write(REG_EXT2, e2[EXTENT_W-1:0]);
		cfg_write(REG_EXT3, e3[EXTENT_W-1:0]);
		cfg_we <= 1'b0;
		src_idle  = (mode == 1) ? 76 : (mode == 3) ? 37 : 0;
		dst_stall = (mode == 2) ? 76 : (mode == 3) ? 37 : 0;
		random_items(count);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset shape: three dimensions of sixteen, the fourth coordinate unused.
		issue(ACT_WRITE, pack_coords(0, 0, 0, 15), 32'h0000_0000);
		issue(ACT_WRITE, pack_coords(15, 15, 15, 0), 32'hFFFF_FFFF);
		issue(ACT_WRITE, pack_coords(5, 10, 3, 0), 32'hA5A5_5A5A);
		issue(ACT_WRITE, pack_coords(15, 0, 15, 0), 32'h8000_0001);
		issue(ACT_READ, pack_coords(0, 0, 0, 0), 32'h0);
		issue(ACT_READ, pack_coords(15, 15, 15, 15), 32'hFFFF_FFFF);
		issue(ACT_READ, pack_coords(5, 10, 3, 9), 32'h1234_5678);
		issue(ACT_NEIGH, pack_coords(0, 0, 0, 0), 32'h0);
		issue(ACT_NEIGH, pack_coords(15, 15, 15, 0), 32'h0);
		issue(ACT_NEIGH, pack_coords(7, 8, 9, 15), 32'h0);
		issue(ACT_NONE, pack_coords(15, 15, 15, 15), 32'hFFFF_FFFF);
		issue(ACT_READ, pack_coords(15, 0, 15, 0), 32'h0);
		random_items(12);

		run_phase(3'd4, 16, 16, 16, 16, 15, 1);
		run_phase(3'd2, 3, 5, 9, 7, 15, 2);
		run_phase(3'd1, 16, 0, 0, 0, 12, 3);
		run_phase(3'd0, 5, 2, 1, 3, 12, 0);
		run_phase(3'd7, 2, 3, 1, 4, 15, 1);
		run_phase(3'd4, 1, 1, 1, 1, 10, 2);
		run_phase(3'd3, 0, 4, 4, 4, 10, 3);
		run_phase(3'd4, 8, 4, 2, 15, 15, 0);
		run_phase(3'd3, 16, 16, 16, 1, 15, 3);

		wait_idle();
		if (sb.mismatches == 0 && sb.pending_results.size() == 0)
			$display("periodic_lattice_site_store test passed");
		else
			$display("periodic_lattice_site_store test failed");
		$finish;
	end

endmodule

/* sim.f */
src/plss_pkg.sv
src/plss_ram.sv
src/plss_queue.sv
src/plss_front.sv
src/plss_back.sv
src/periodic_lattice_site_store.sv
tb/tb.sv
